[rtl/core/qrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, root class codes and the request record of the quadratic
// root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 34;
    localparam int D_W       = 34;
    localparam int PROD_W    = 2 * COEF_W;
    // one result bit per square root step: D_W/2 integer bits plus fraction
    localparam int SQ_STEPS  = D_W / 2 + FRAC_BITS;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int SQ_REM_W  = ROOT_W + 3;
    localparam int NUM_W     = OUT_W + 1;
    localparam int DEN_W     = COEF_W + 1;
    localparam int DIV_STEPS = OUT_W;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = Q_PTR_W + 1;

    typedef enum logic [1:0] {
        CLS_DISTINCT = 2'd0,
        CLS_EQUAL    = 2'd1,
        CLS_COMPLEX  = 2'd2,
        CLS_DEGEN    = 2'd3
    } root_class_t;

    typedef struct packed {
        root_class_t              cls;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [D_W-1:0]    d;
    } qrs_item_t;

endpackage

[rtl/core/qrs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_front
// Accepts coefficient requests, forms the discriminant in two stages and
// classifies the roots.
// ----------------------------------------------------------------------------
module qrs_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output logic                              push,
    output qrs_pkg::qrs_item_t                push_item,
    input  logic                              q_full
);

    logic                              v1_reg;
    logic                              v1_next;
    logic signed [qrs_pkg::COEF_W-1:0] a1_reg;
    logic signed [qrs_pkg::COEF_W-1:0] b1_reg;
    logic signed [qrs_pkg::PROD_W-1:0] bb_reg;
    logic signed [qrs_pkg::PROD_W-1:0] ac_reg;
    logic                              v2_reg;
    logic                              v2_next;
    qrs_pkg::qrs_item_t                item_reg;
    qrs_pkg::qrs_item_t                item_next;
    logic                              adv;
    logic signed [qrs_pkg::D_W-1:0]    d_calc;

    assign push     = v2_reg && !q_full;
    assign adv      = !v2_reg || !q_full;
    assign in_ready = adv;
    assign v1_next  = in_valid;
    assign v2_next  = v1_reg;

    always_comb
    begin
        d_calc = qrs_pkg::D_W'(bb_reg) - (qrs_pkg::D_W'(ac_reg) <<< 2);
        item_next.a = a1_reg;
        item_next.b = b1_reg;
        item_next.d = d_calc;
        if (a1_reg == '0)
        begin
            item_next.cls = qrs_pkg::CLS_DEGEN;
        end
        else if (d_calc < 0)
        begin
            item_next.cls = qrs_pkg::CLS_COMPLEX;
        end
        else if (d_calc == '0)
        begin
            item_next.cls = qrs_pkg::CLS_EQUAL;
        end
        else
        begin
            item_next.cls = qrs_pkg::CLS_DISTINCT;
        end
    end

    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg   <= coef_a;
            b1_reg   <= coef_b;
            bb_reg   <= coef_b * coef_b;
            ac_reg   <= coef_a * coef_c;
            item_reg <= item_next;
        end
    end

endmodule

[rtl/core/qrs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_queue
// Small FIFO of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module qrs_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qrs_pkg::qrs_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output qrs_pkg::qrs_item_t pop_item
);

    qrs_pkg::qrs_item_t                mem_reg [0:qrs_pkg::Q_DEPTH-1];
    logic [qrs_pkg::Q_PTR_W-1:0]       wr_ptr_reg;
    logic [qrs_pkg::Q_PTR_W-1:0]       wr_ptr_next;
    logic [qrs_pkg::Q_PTR_W-1:0]       rd_ptr_reg;
    logic [qrs_pkg::Q_PTR_W-1:0]       rd_ptr_next;
    logic [qrs_pkg::Q_CNT_W-1:0]       cnt_reg;
    logic [qrs_pkg::Q_CNT_W-1:0]       cnt_next;
    logic                              do_pop;

    assign full     = cnt_reg == qrs_pkg::Q_CNT_W'(qrs_pkg::Q_DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/qrs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_back
// Pipelined digit-by-digit square root followed by two pipelined restoring
// dividers; output register holds the finished result.
// ----------------------------------------------------------------------------
module qrs_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  qrs_pkg::qrs_item_t               q_item,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       root_class,
    output logic signed [qrs_pkg::OUT_W-1:0] root_plus,
    output logic signed [qrs_pkg::OUT_W-1:0] root_minus,
    output logic signed [qrs_pkg::OUT_W-1:0] discriminant
);

    localparam int SQ = qrs_pkg::SQ_STEPS;
    localparam int DV = qrs_pkg::DIV_STEPS;

    logic adv;

    // square root stages
    logic                                 sq_v_reg    [0:SQ];
    qrs_pkg::qrs_item_t                   sq_item_reg [0:SQ];
    logic [qrs_pkg::ROOT_W-1:0]           sq_root_reg [0:SQ];
    logic [qrs_pkg::SQ_REM_W-1:0]         sq_rem_reg  [0:SQ];

    // divider stages; num holds the magnitude, then the quotient bits
    logic                                 dv_v_reg    [0:DV];
    qrs_pkg::qrs_item_t                   dv_item_reg [0:DV];
    logic [qrs_pkg::DEN_W-1:0]            dv_den_reg  [0:DV];
    logic [qrs_pkg::OUT_W-1:0]            dv_np_reg   [0:DV];
    logic [qrs_pkg::OUT_W-1:0]            dv_nm_reg   [0:DV];
    logic [qrs_pkg::DEN_W-1:0]            dv_rp_reg   [0:DV];
    logic [qrs_pkg::DEN_W-1:0]            dv_rm_reg   [0:DV];
    logic                                 dv_sp_reg   [0:DV];
    logic                                 dv_sm_reg   [0:DV];

    logic                                 out_v_reg;
    logic [1:0]                           cls_reg;
    logic signed [qrs_pkg::OUT_W-1:0]     rp_reg;
    logic signed [qrs_pkg::OUT_W-1:0]     rm_reg;
    logic signed [qrs_pkg::OUT_W-1:0]     d_reg;

    assign adv          = !out_v_reg || out_ready;
    assign pop          = adv && !q_empty;
    assign out_valid    = out_v_reg;
    assign root_class   = cls_reg;
    assign root_plus    = rp_reg;
    assign root_minus   = rm_reg;
    assign discriminant = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_item_reg[0] <= q_item;
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SQ; k++)
        begin : g_sq
            // pair index counts down from the top of d into the fraction
            localparam int PI = qrs_pkg::D_W / 2 - 1 - k;
            logic [1:0]                   pair;
            logic [qrs_pkg::SQ_REM_W-1:0] rem_sh;
            logic [qrs_pkg::SQ_REM_W-1:0] trial;
            logic                         ge;

            if (PI >= 0)
            begin : g_pair
                assign pair = sq_item_reg[k].d[2*PI+1 -: 2];
            end
            else
            begin : g_zero
                assign pair = 2'b00;
            end

            assign rem_sh = {sq_rem_reg[k][qrs_pkg::SQ_REM_W-3:0], pair};
            assign trial  = {1'b0, sq_root_reg[k], 2'b01};
            assign ge     = rem_sh >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_v_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    sq_v_reg[k+1] <= sq_v_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_item_reg[k+1] <= sq_item_reg[k];
                    sq_rem_reg[k+1]  <= ge ? rem_sh - trial : rem_sh;
                    sq_root_reg[k+1] <= {sq_root_reg[k][qrs_pkg::ROOT_W-2:0], ge};
                end
            end
        end
    endgenerate

    // numerators -b*2^F +/- s, split into magnitude and quotient sign
    logic signed [qrs_pkg::NUM_W-1:0]  nb;
    logic signed [qrs_pkg::NUM_W-1:0]  s_ext;
    logic signed [qrs_pkg::NUM_W-1:0]  np;
    logic signed [qrs_pkg::NUM_W-1:0]  nm;
    logic signed [qrs_pkg::NUM_W-1:0]  np_abs;
    logic signed [qrs_pkg::NUM_W-1:0]  nm_abs;
    logic signed [qrs_pkg::DEN_W-1:0]  a_ext;
    logic [qrs_pkg::DEN_W-1:0]         a_abs;
    logic                              a_neg;

    always_comb
    begin
        nb     = -(qrs_pkg::NUM_W'(sq_item_reg[SQ].b) <<< qrs_pkg::FRAC_BITS);
        s_ext  = $signed({1'b0, sq_root_reg[SQ]});
        np     = nb + s_ext;
        nm     = nb - s_ext;
        np_abs = np[qrs_pkg::NUM_W-1] ? -np : np;
        nm_abs = nm[qrs_pkg::NUM_W-1] ? -nm : nm;
        a_ext  = qrs_pkg::DEN_W'(sq_item_reg[SQ].a);
        a_neg  = a_ext[qrs_pkg::DEN_W-1];
        a_abs  = a_neg ? qrs_pkg::DEN_W'(-a_ext) : qrs_pkg::DEN_W'(a_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= sq_v_reg[SQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_item_reg[0] <= sq_item_reg[SQ];
            dv_den_reg[0]  <= a_abs << 1;
            dv_np_reg[0]   <= np_abs[qrs_pkg::OUT_W-1:0];
            dv_nm_reg[0]   <= nm_abs[qrs_pkg::OUT_W-1:0];
            dv_rp_reg[0]   <= '0;
            dv_rm_reg[0]   <= '0;
            dv_sp_reg[0]   <= np[qrs_pkg::NUM_W-1] ^ a_neg;
            dv_sm_reg[0]   <= nm[qrs_pkg::NUM_W-1] ^ a_neg;
        end
    end

    generate
        for (k = 0; k < DV; k++)
        begin : g_dv
            logic [qrs_pkg::DEN_W:0] rp_sh;
            logic [qrs_pkg::DEN_W:0] rm_sh;
            logic [qrs_pkg::DEN_W:0] den_x;
            logic                    gp;
            logic                    gm;
            logic [qrs_pkg::DEN_W:0] rp_new;
            logic [qrs_pkg::DEN_W:0] rm_new;

            assign rp_sh  = {dv_rp_reg[k], dv_np_reg[k][qrs_pkg::OUT_W-1]};
            assign rm_sh  = {dv_rm_reg[k], dv_nm_reg[k][qrs_pkg::OUT_W-1]};
            assign den_x  = {1'b0, dv_den_reg[k]};
            assign gp     = rp_sh >= den_x;
            assign gm     = rm_sh >= den_x;
            assign rp_new = gp ? rp_sh - den_x : rp_sh;
            assign rm_new = gm ? rm_sh - den_x : rm_sh;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_v_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_v_reg[k+1] <= dv_v_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_item_reg[k+1] <= dv_item_reg[k];
                    dv_den_reg[k+1]  <= dv_den_reg[k];
                    dv_sp_reg[k+1]   <= dv_sp_reg[k];
                    dv_sm_reg[k+1]   <= dv_sm_reg[k];
                    dv_rp_reg[k+1]   <= rp_new[qrs_pkg::DEN_W-1:0];
                    dv_rm_reg[k+1]   <= rm_new[qrs_pkg::DEN_W-1:0];
                    dv_np_reg[k+1]   <= {dv_np_reg[k][qrs_pkg::OUT_W-2:0], gp};
                    dv_nm_reg[k+1]   <= {dv_nm_reg[k][qrs_pkg::OUT_W-2:0], gm};
                end
            end
        end
    endgenerate

    logic                             real_roots;
    logic signed [qrs_pkg::OUT_W-1:0] qp;
    logic signed [qrs_pkg::OUT_W-1:0] qm;

    always_comb
    begin
        real_roots = dv_item_reg[DV].cls == qrs_pkg::CLS_DISTINCT
                  || dv_item_reg[DV].cls == qrs_pkg::CLS_EQUAL;
        qp = dv_sp_reg[DV] ? -$signed(dv_np_reg[DV]) : $signed(dv_np_reg[DV]);
        qm = dv_sm_reg[DV] ? -$signed(dv_nm_reg[DV]) : $signed(dv_nm_reg[DV]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= dv_v_reg[DV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg <= dv_item_reg[DV].cls;
            rp_reg  <= real_roots ? qp : '0;
            rm_reg  <= real_roots ? qm : '0;
            d_reg   <= dv_item_reg[DV].d;
        end
    end

endmodule

[rtl/core/quadratic_root_solver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c in signed fixed point with 16 fraction bits.
// ----------------------------------------------------------------------------
// Takes one coefficient request per cycle while in_ready is high and returns
// one result per request, in order. A request is registered on acceptance,
// then one front stage forms and classifies the discriminant, a write puts
// it into the request queue, then come a load stage, a 33-stage square root
// pipeline (one root bit per stage), a numerator stage, a 34-stage divider
// (one quotient bit per stage) and the output register. The throughput of
// one request per cycle is set by those pipelines unless a full queue or a
// low out_ready stalls them.
// Square root and quotient are truncated; complex and zero-a cases give
// zero roots.
module quadratic_root_solver
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        root_class,
    output logic signed [qrs_pkg::OUT_W-1:0]  root_plus,
    output logic signed [qrs_pkg::OUT_W-1:0]  root_minus,
    output logic signed [qrs_pkg::OUT_W-1:0]  discriminant
);

    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    qrs_pkg::qrs_item_t push_item;
    qrs_pkg::qrs_item_t pop_item;

    qrs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    qrs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    qrs_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (pop_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .root_class   (root_class),
        .root_plus    (root_plus),
        .root_minus   (root_minus),
        .discriminant (discriminant)
    );

endmodule
